// ===== src/solitaire_stream_cipher_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SOLITAIRE_STREAM_CIPHER_DEFINES_SVH
`define SOLITAIRE_STREAM_CIPHER_DEFINES_SVH

// Checked at every edge outside reset.
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ssc_pkg.sv =====
package ssc_pkg;

  localparam int unsigned DECK_SIZE = 54;

  typedef logic [5:0] card_t;

  localparam card_t JOKER_A   = 6'd53;
  localparam card_t JOKER_B   = 6'd54;
  localparam card_t LAST_POS  = 6'd53;
  localparam card_t MAX_KEY   = 6'd52;
  localparam card_t MAX_ROUND = 6'd53;

  localparam logic [2:0] GROUP_LAST = 3'd4;
  localparam logic [4:0] LETTER_X   = 5'd24;

  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UBASE = 8'h40;
  localparam logic [7:0] CH_LBASE = 8'h60;

  localparam logic [6:0] ALPHA     = 7'd26;
  localparam logic [6:0] TWO_ALPHA = 7'd52;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CIPHER = 2'd1,
    OP_KEY    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    P_SCAN,
    P_MOVA,
    P_MOVB,
    P_TCUT,
    P_CCUT
  } pass_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GO,
    S_WAIT,
    S_EVAL,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic  start;
    pass_t kind;
    logic  load_we;
    card_t load_pos;
    card_t load_val;
  } dp_cmd_t;

  typedef struct packed {
    logic  done;
    logic  afound;
    logic  bfound;
    card_t key;
  } dp_status_t;

  function automatic card_t clamp53(card_t x);
    return (x > LAST_POS) ? LAST_POS : x;
  endfunction

  function automatic logic [7:0] subst(logic [4:0] m, card_t k, logic dec);
    logic [6:0] s;
    s = dec ? (TWO_ALPHA + {2'b00, m} - {1'b0, k}) : ({2'b00, m} + {1'b0, k});
    if (s >= TWO_ALPHA) s = s - TWO_ALPHA;
    if (s >= ALPHA) s = s - ALPHA;
    if (s == 7'd0) s = ALPHA;
    return CH_UBASE + {1'b0, s};
  endfunction

endpackage

// ===== src/ssc_if.sv =====
interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] deck_position;
  logic [5:0] card_value;
  logic [7:0] char_in;
  logic       end_of_message;

  modport source(output valid, opcode, deck_position, card_value, char_in, end_of_message,
                 input ready);
  modport sink(input valid, opcode, deck_position, card_value, char_in, end_of_message,
               output ready);
endinterface

interface ssc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [5:0] key_card;
  logic       status;
  logic       last;

  modport source(output valid, char_out, key_card, status, last, input ready);
  modport sink(input valid, char_out, key_card, status, last, output ready);
endinterface

// ===== src/ssc_datapath.sv =====
module ssc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ssc_pkg::dp_cmd_t    cmd,
  output ssc_pkg::dp_status_t stat
);
  import ssc_pkg::*;

  card_t mem0 [DECK_SIZE];
  card_t mem1 [DECK_SIZE];
  card_t rd0_r, rd1_r;

  logic  bank_r, busy_r, wr_vld_r, done_r, afound_r, bfound_r;
  card_t cnt_r, wr_idx_r;
  pass_t kind_r;
  card_t p1_r, p2_r, apos_r, bpos_r, top_r, bot_r, key_r;

  card_t      st_p1, st_p2, raddr, waddr, wdat, wpass, off;
  logic [6:0] c7, p17, p27, src;
  logic       we0, we1;

  always_comb begin
    st_p1 = '0;
    st_p2 = '0;
    case (cmd.kind)
      P_MOVA: begin
        st_p1 = apos_r;
        st_p2 = (apos_r == LAST_POS) ? 6'd1 : apos_r + 6'd1;
      end
      P_MOVB: begin
        st_p1 = bpos_r;
        if (bpos_r < MAX_KEY) st_p2 = bpos_r + 6'd2;
        else if (bpos_r == MAX_KEY) st_p2 = 6'd1;
        else st_p2 = 6'd2;
      end
      P_TCUT: begin
        st_p1 = (apos_r < bpos_r) ? apos_r : bpos_r;
        st_p2 = (apos_r < bpos_r) ? bpos_r : apos_r;
      end
      P_CCUT: st_p1 = clamp53(bot_r);
      default: st_p1 = '0;
    endcase
  end

  always_comb begin
    c7  = {1'b0, cnt_r};
    p17 = {1'b0, p1_r};
    p27 = {1'b0, p2_r};
    src = c7;
    case (kind_r)
      P_MOVA, P_MOVB: begin
        if (p1_r < p2_r) begin
          if (c7 >= p17 && c7 < p27) src = c7 + 7'd1;
          else if (c7 == p27) src = p17;
        end else if (p1_r > p2_r) begin
          if (c7 > p27 && c7 <= p17) src = c7 - 7'd1;
          else if (c7 == p27) src = p17;
        end
      end
      P_TCUT: begin
        if (c7 < {1'b0, LAST_POS} - p27) src = p27 + 7'd1 + c7;
        else if (c7 < 7'(DECK_SIZE) - p17) src = p17 + p27 + c7 - {1'b0, LAST_POS};
        else src = c7 + p17 - 7'(DECK_SIZE);
      end
      P_CCUT: begin
        if (c7 == {1'b0, LAST_POS}) src = c7;
        else if (c7 < {1'b0, LAST_POS} - p17) src = p17 + c7;
        else src = c7 + p17 - {1'b0, LAST_POS};
      end
      default: src = c7;
    endcase
    raddr = src[5:0];
  end

  assign wpass = bank_r ? rd1_r : rd0_r;
  assign waddr = cmd.load_we ? cmd.load_pos : wr_idx_r;
  assign wdat  = cmd.load_we ? cmd.load_val : wpass;
  assign we0   = (cmd.load_we && !bank_r) || (wr_vld_r && bank_r);
  assign we1   = (cmd.load_we && bank_r) || (wr_vld_r && !bank_r);
  assign off   = (wr_idx_r == '0) ? clamp53(wpass) : clamp53(top_r);

  always_ff @(posedge clk) begin
    if (we0) mem0[waddr] <= wdat;
    rd0_r <= mem0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[waddr] <= wdat;
    rd1_r <= mem1[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      busy_r   <= 1'b0;
      wr_vld_r <= 1'b0;
      done_r   <= 1'b0;
      afound_r <= 1'b0;
      bfound_r <= 1'b0;
      cnt_r    <= '0;
      kind_r   <= P_SCAN;
    end else begin
      done_r   <= 1'b0;
      wr_vld_r <= busy_r;
      if (cmd.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        kind_r   <= cmd.kind;
        afound_r <= 1'b0;
        bfound_r <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r == LAST_POS) busy_r <= 1'b0;
        cnt_r <= cnt_r + 6'd1;
      end
      if (wr_vld_r) begin
        if (wpass == JOKER_A && !afound_r) afound_r <= 1'b1;
        if (wpass == JOKER_B && !bfound_r) bfound_r <= 1'b1;
        if (wr_idx_r == LAST_POS) begin
          bank_r <= ~bank_r;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r <= cnt_r;
    if (cmd.start) begin
      p1_r <= st_p1;
      p2_r <= st_p2;
    end
    if (wr_vld_r) begin
      if (wpass == JOKER_A && !afound_r) apos_r <= wr_idx_r;
      if (wpass == JOKER_B && !bfound_r) bpos_r <= wr_idx_r;
      if (wr_idx_r == LAST_POS) bot_r <= wpass;
      if (wr_idx_r == '0) top_r <= wpass;
      if (wr_idx_r == off) key_r <= wpass;
    end
  end

  assign stat.done   = done_r;
  assign stat.afound = afound_r;
  assign stat.bfound = bfound_r;
  assign stat.key    = key_r;

endmodule

// ===== src/ssc_ctrl.sv =====
module ssc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_data,
  ssc_in_if.sink              in_bus,
  ssc_out_if.source           out_bus,
  output ssc_pkg::dp_cmd_t    cmd,
  input  ssc_pkg::dp_status_t stat
);
  import ssc_pkg::*;

  state_t     state_r, state_nxt;
  pass_t      kind_r, kind_nxt;
  opcode_t    op_r, op_nxt, in_op;
  logic [4:0] m_r, m_nxt;
  logic       eom_r, eom_nxt, mode_r;
  logic [2:0] group_r, group_nxt, group_inc;
  card_t      round_r, round_nxt;
  logic       out_vld_r, out_vld_nxt, st_r, st_nxt, last_r, last_nxt;
  logic [7:0] char_r, char_nxt;
  card_t      key_r, key_nxt;

  logic       accept, is_up, is_lo, is_letter, out_free, key_ok, more, start_go;
  logic [4:0] letter;

  assign in_op     = opcode_t'(in_bus.opcode);
  assign accept    = in_bus.valid && (state_r == S_IDLE);
  assign is_up     = in_bus.char_in >= CH_UA && in_bus.char_in <= CH_UZ;
  assign is_lo     = in_bus.char_in >= CH_LA && in_bus.char_in <= CH_LZ;
  assign is_letter = is_up || is_lo;
  assign letter    = is_up ? 5'(in_bus.char_in - CH_UBASE) : 5'(in_bus.char_in - CH_LBASE);
  assign start_go  = (in_op == OP_KEY) || (in_op == OP_CIPHER &&
                     (is_letter || (in_bus.end_of_message && group_r != '0)));
  assign out_free  = !out_vld_r || out_bus.ready;
  assign key_ok    = stat.key <= MAX_KEY;
  assign group_inc = (group_r == GROUP_LAST) ? 3'd0 : group_r + 3'd1;
  assign more      = (op_r == OP_CIPHER) && eom_r && (group_inc != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && start_go) state_nxt = S_GO;
      S_GO:   state_nxt = S_WAIT;
      S_WAIT: if (stat.done) state_nxt = S_EVAL;
      S_EVAL: begin
        case (kind_r)
          P_SCAN: state_nxt = stat.afound ? S_GO : S_ERR;
          P_MOVA: state_nxt = stat.bfound ? S_GO : S_ERR;
          P_MOVB: state_nxt = (stat.afound && stat.bfound) ? S_GO : S_ERR;
          P_TCUT: state_nxt = S_GO;
          P_CCUT: begin
            if (key_ok) state_nxt = S_EMIT;
            else if (round_r == MAX_ROUND || !stat.afound) state_nxt = S_ERR;
            else state_nxt = S_GO;
          end
          default: state_nxt = S_ERR;
        endcase
      end
      S_EMIT: if (out_free) state_nxt = more ? S_GO : S_IDLE;
      S_ERR:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt     = kind_r;
    op_nxt       = op_r;
    m_nxt        = m_r;
    eom_nxt      = eom_r;
    group_nxt    = group_r;
    round_nxt    = round_r;
    out_vld_nxt  = out_vld_r && !out_bus.ready;
    char_nxt     = char_r;
    key_nxt      = key_r;
    st_nxt       = st_r;
    last_nxt     = last_r;
    in_bus.ready = (state_r == S_IDLE);
    cmd.start    = (state_r == S_GO);
    cmd.kind     = kind_r;
    cmd.load_we  = accept && in_op == OP_LOAD && in_bus.deck_position <= LAST_POS;
    cmd.load_pos = in_bus.deck_position;
    cmd.load_val = in_bus.card_value;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          eom_nxt   = in_bus.end_of_message;
          m_nxt     = is_letter ? letter : LETTER_X;
          kind_nxt  = P_SCAN;
          round_nxt = '0;
        end
      end
      S_EVAL: begin
        case (kind_r)
          P_SCAN: kind_nxt = P_MOVA;
          P_MOVA: kind_nxt = P_MOVB;
          P_MOVB: kind_nxt = P_TCUT;
          P_TCUT: kind_nxt = P_CCUT;
          P_CCUT: begin
            kind_nxt  = P_MOVA;
            round_nxt = round_r + 6'd1;
          end
          default: kind_nxt = P_SCAN;
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          char_nxt    = (op_r == OP_CIPHER) ? subst(m_r, stat.key, mode_r) : 8'd0;
          key_nxt     = stat.key;
          st_nxt      = 1'b0;
          last_nxt    = !more;
          if (op_r == OP_CIPHER) group_nxt = (eom_r && !more) ? 3'd0 : group_inc;
          if (more) begin
            m_nxt     = LETTER_X;
            kind_nxt  = P_SCAN;
            round_nxt = '0;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          char_nxt    = 8'd0;
          key_nxt     = '0;
          st_nxt      = 1'b1;
          last_nxt    = 1'b1;
          if (op_r == OP_CIPHER && eom_r) group_nxt = '0;
        end
      end
      default: out_vld_nxt = out_vld_r && !out_bus.ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      group_r   <= '0;
      mode_r    <= 1'b0;
      out_vld_r <= 1'b0;
      kind_r    <= P_SCAN;
      round_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      group_r   <= group_nxt;
      out_vld_r <= out_vld_nxt;
      kind_r    <= kind_nxt;
      round_r   <= round_nxt;
      if (cfg_we) mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    m_r    <= m_nxt;
    eom_r  <= eom_nxt;
    char_r <= char_nxt;
    key_r  <= key_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign out_bus.valid    = out_vld_r;
  assign out_bus.char_out = char_r;
  assign out_bus.key_card = key_r;
  assign out_bus.status   = st_r;
  assign out_bus.last     = last_r;

endmodule

// ===== src/solitaire_stream_cipher.sv =====
// Channel   Direction  Payload
// in_bus    in         opcode, deck_position, card_value, char_in, end_of_message
// out_bus   out        char_out, key_card, status, last
// cfg       in         cfg_we, cfg_data (decrypt mode)
//
// A load beat writes one card into the deck memory when its position is in range. Each pass
// copies the deck between the two deck memories. A key card starts with a scan pass and then
// runs rounds of four passes, with one further round each time a joker comes up as output.
// Reset is synchronous and clears control state only; the deck reads as undefined until
// loaded. A stalled result holds its register while load beats are still taken.
module solitaire_stream_cipher (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_data,
  ssc_in_if.sink    in_bus,
  ssc_out_if.source out_bus
);
  import ssc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  ssc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cmd      (cmd),
    .stat     (stat)
  );

  ssc_datapath u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

endmodule

// ===== src/ssc_checker.sv =====
`include "solitaire_stream_cipher_defines.svh"

module ssc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic [5:0] out_key,
  input logic       out_status,
  input logic       out_last
);
  `SSC_ASSERT(a_hold, (out_valid && !out_ready) |=> out_valid, "result beat dropped")
  `SSC_ASSERT(a_err, (out_valid && out_status) |-> (out_last && out_key == 6'd0 && out_char == 8'd0), "bad error beat")
  `SSC_ASSERT(a_letter, (out_valid && !out_status && out_char != 8'd0) |-> (out_char >= 8'h41 && out_char <= 8'h5A), "cipher byte not a letter")
  `SSC_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "result valid after reset")
endmodule

bind solitaire_stream_cipher ssc_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_char   (out_bus.char_out),
  .out_key    (out_bus.key_card),
  .out_status (out_bus.status),
  .out_last   (out_bus.last)
);
